// ===== hdl/cht_pkg.sv =====
// shared types and constants of the chained hash table
`timescale 1ns / 1ps

package cht_pkg;

  localparam int unsigned MaxBucketsDefault  = 256;
  localparam int unsigned PoolEntriesDefault = 1024;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 11;
  localparam int unsigned CfgW   = 9;
  localparam int unsigned CfgReset = 256;

  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CmdW-1:0] CMD_SEARCH = 2'd2;

  localparam logic [StatW-1:0] ST_OK   = 2'd0;
  localparam logic [StatW-1:0] ST_MISS = 2'd1;
  localparam logic [StatW-1:0] ST_FULL = 2'd2;

  // input tdata: command, key, value
  localparam int unsigned InDataW  = 72;
  // output tdata: status, found_value, found_key, entry_count
  localparam int unsigned OutDataW = 80;

  // request handed from the sequencer to the modulo unit
  typedef struct packed {
    logic            start;
    logic [KeyW-1:0] key;
    logic [CfgW-1:0] divisor;
  } mod_req_t;

endpackage

// ===== hdl/cht_mod_unit.sv =====
// iterative restoring modulo unit, one key bit per cycle
`timescale 1ns / 1ps

module cht_mod_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cht_pkg::mod_req_t          req_i,
  output logic                       done_o,
  output logic [cht_pkg::CfgW-1:0]   rem_o
);

  localparam int unsigned BitW = $clog2(cht_pkg::KeyW + 1);

  logic [cht_pkg::KeyW-1:0] shift_q, shift_d;
  logic [cht_pkg::CfgW:0]   rem_q, rem_d;
  logic [cht_pkg::CfgW-1:0] div_q, div_d;
  logic [BitW-1:0]          cnt_q, cnt_d;
  logic                     busy_q, busy_d, done_q, done_d;
  logic [cht_pkg::CfgW:0]   trial;

  // load a new request, or do one shift-subtract step
  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    trial   = {rem_q[cht_pkg::CfgW-1:0], shift_q[cht_pkg::KeyW-1]};
    if (req_i.start) begin
      shift_d = req_i.key;
      rem_d   = '0;
      div_d   = req_i.divisor;
      cnt_d   = BitW'(cht_pkg::KeyW);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      shift_d = {shift_q[cht_pkg::KeyW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == BitW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[cht_pkg::CfgW-1:0];

endmodule

// ===== hdl/chained_hash_table_core.sv =====
// top level: sequencer, bucket heads and entry pool of the hash table
`timescale 1ns / 1ps

// Hash table with separate chaining. One request is taken at a time; s_axis_tready is low
// until its result has been taken off m_axis. A request first passes through the bit-serial
// modulo unit that finds the bucket and then reads the bucket head. An insert that finds a
// free entry then writes the entry, its link and the bucket head together. Remove and search
// read each chain entry visited in turn (one pool memory read port), and a remove that hits
// then puts the entry on the free list. Bucket heads carry one valid bit each, so no clearing
// pass follows reset.

module chained_hash_table_core #(
  parameter int unsigned MAX_BUCKETS  = cht_pkg::MaxBucketsDefault,
  parameter int unsigned POOL_ENTRIES = cht_pkg::PoolEntriesDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cht_pkg::CfgW-1:0]        cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // command [1:0], key [33:2], value [65:34], zero fill
  input  logic [cht_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status [1:0], found_value [33:2], found_key [65:34], entry_count [76:66], zero fill
  output logic [cht_pkg::OutDataW-1:0]    m_axis_tdata
);

  localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned EW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned FW = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned CW = cht_pkg::CountW;
  localparam int unsigned KW = cht_pkg::KeyW;
  localparam int unsigned VW = cht_pkg::ValW;

  localparam logic [3:0] S_IDLE = 4'd0, S_MOD = 4'd1, S_HRD = 4'd2, S_HWT = 4'd3,
                         S_ERD = 4'd4, S_EWT = 4'd5, S_INS = 4'd6, S_FRD = 4'd7,
                         S_FWT = 4'd8, S_OUT = 4'd9;

  logic [3:0] state_q, state_d;

  // configuration register
  logic [cht_pkg::CfgW-1:0] cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cht_pkg::CfgW'(cht_pkg::CfgReset);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  logic [cht_pkg::CfgW-1:0] divisor;
  always_comb begin
    if (cfg_q == '0) begin
      divisor = cht_pkg::CfgW'(1);
    end else if ({23'd0, cfg_q} > 32'(MAX_BUCKETS)) begin
      divisor = cht_pkg::CfgW'(MAX_BUCKETS);
    end else begin
      divisor = cfg_q;
    end
  end

  // request registers
  logic [cht_pkg::CmdW-1:0] cmd_q;
  logic [KW-1:0] key_q;
  logic [VW-1:0] val_q;
  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= s_axis_tdata[1:0];
      key_q <= s_axis_tdata[33:2];
      val_q <= s_axis_tdata[65:34];
    end
  end

  // modulo unit
  cht_pkg::mod_req_t mreq;
  logic mdone;
  logic [cht_pkg::CfgW-1:0] mrem;
  assign mreq.start   = accept;
  assign mreq.key     = s_axis_tdata[33:2];
  assign mreq.divisor = divisor;

  cht_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mdone),
    .rem_o  (mrem)
  );

  logic [BW-1:0] bucket_q;

  // bucket head memory with one valid bit per bucket
  logic [EW:0] head_mem [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] head_vld_q;
  logic [EW:0] head_rd_q;
  logic head_rvld_q;
  logic head_we;
  logic [EW:0] head_wd;

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[bucket_q] <= head_wd;
    end
    head_rd_q <= head_mem[bucket_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q  <= '0;
      head_rvld_q <= 1'b0;
    end else begin
      if (head_we) begin
        head_vld_q[bucket_q] <= 1'b1;
      end
      head_rvld_q <= head_vld_q[bucket_q];
    end
  end

  logic [EW:0] head_val;
  assign head_val = head_rvld_q ? head_rd_q : {1'b1, {EW{1'b0}}};

  // entry pool: key, value and link share one read address; the link is written at its own address
  logic [KW-1:0] ekey_mem [POOL_ENTRIES];
  logic [VW-1:0] eval_mem [POOL_ENTRIES];
  logic [EW:0]   elink_mem [POOL_ENTRIES];
  logic [EW-1:0] rd_addr;
  logic [KW-1:0] ekey_rd_q;
  logic [VW-1:0] eval_rd_q;
  logic [EW:0]   elink_rd_q;
  logic ent_we, link_we;
  logic [EW-1:0] ent_wa, link_wa;
  logic [EW:0]   link_wd;

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ekey_mem[ent_wa] <= key_q;
      eval_mem[ent_wa] <= val_q;
    end
    ekey_rd_q <= ekey_mem[rd_addr];
    eval_rd_q <= eval_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      elink_mem[link_wa] <= link_wd;
    end
    elink_rd_q <= elink_mem[rd_addr];
  end

  // chain walk and pool bookkeeping
  logic [EW:0] cur_q, cur_d, prev_q, prev_d, free_q, free_d, ins_q, ins_d;
  logic [FW-1:0] fresh_q, fresh_d;
  logic [CW-1:0] held_q, held_d;
  logic [FW-1:0] steps_q, steps_d;
  logic [cht_pkg::StatW-1:0] st_q, st_d;
  logic [VW-1:0] fv_q, fv_d;
  logic [KW-1:0] fk_q, fk_d;
  logic op_walk;
  assign op_walk = (cmd_q == cht_pkg::CMD_REMOVE) || (cmd_q == cht_pkg::CMD_SEARCH);

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    free_d  = free_q;
    ins_d   = ins_q;
    fresh_d = fresh_q;
    held_d  = held_q;
    steps_d = steps_q;
    st_d    = st_q;
    fv_d    = fv_q;
    fk_d    = fk_q;
    head_we = 1'b0;
    head_wd = ins_q;
    ent_we  = 1'b0;
    ent_wa  = ins_q[EW-1:0];
    link_we = 1'b0;
    link_wa = ins_q[EW-1:0];
    link_wd = head_val;
    rd_addr = cur_q[EW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        st_d = cht_pkg::ST_MISS;
        fv_d = '0;
        fk_d = '0;
        if (mdone) begin
          state_d = S_HRD;
        end
      end
      S_HRD: begin
        state_d = S_HWT;
        rd_addr = free_q[EW-1:0];
      end
      S_HWT: begin
        // head_val and free link now valid
        if (cmd_q == cht_pkg::CMD_INSERT) begin
          if (!free_q[EW]) begin
            ins_d   = free_q;
            free_d  = elink_rd_q;
            state_d = S_INS;
          end else if (fresh_q < FW'(POOL_ENTRIES)) begin
            ins_d   = {1'b0, fresh_q[EW-1:0]};
            fresh_d = fresh_q + 1'b1;
            state_d = S_INS;
          end else begin
            st_d    = cht_pkg::ST_FULL;
            state_d = S_OUT;
          end
        end else if (op_walk) begin
          cur_d   = head_val;
          prev_d  = {1'b1, {EW{1'b0}}};
          steps_d = '0;
          state_d = head_val[EW] ? S_OUT : S_ERD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_INS: begin
        ent_we  = 1'b1;
        link_we = 1'b1;
        head_we = 1'b1;
        head_wd = ins_q;
        held_d  = held_q + 1'b1;
        st_d    = cht_pkg::ST_OK;
        state_d = S_OUT;
      end
      S_ERD: begin
        state_d = S_EWT;
      end
      S_EWT: begin
        if (ekey_rd_q == key_q) begin
          st_d = cht_pkg::ST_OK;
          fv_d = eval_rd_q;
          fk_d = ekey_rd_q;
          if (cmd_q == cht_pkg::CMD_REMOVE) begin
            // unlink, then push onto free list
            if (prev_q[EW]) begin
              head_we = 1'b1;
              head_wd = elink_rd_q;
            end else begin
              link_we = 1'b1;
              link_wa = prev_q[EW-1:0];
              link_wd = elink_rd_q;
            end
            state_d = S_FRD;
            if (held_q != '0) begin
              held_d = held_q - 1'b1;
            end
          end else begin
            state_d = S_OUT;
          end
        end else begin
          prev_d  = cur_q;
          cur_d   = elink_rd_q;
          steps_d = steps_q + 1'b1;
          if (elink_rd_q[EW] || (steps_q + 1'b1) >= FW'(POOL_ENTRIES)) begin
            state_d = S_OUT;
          end else begin
            state_d = S_ERD;
          end
        end
      end
      S_FRD: begin
        link_we = 1'b1;
        link_wa = cur_q[EW-1:0];
        link_wd = free_q;
        free_d  = cur_q;
        state_d = S_FWT;
      end
      S_FWT: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      free_q  <= {1'b1, {EW{1'b0}}};
      fresh_q <= '0;
      held_q  <= '0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      fresh_q <= fresh_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    ins_q   <= ins_d;
    steps_q <= steps_d;
    st_q    <= st_d;
    fv_q    <= fv_d;
    fk_q    <= fk_d;
    if (mdone) begin
      bucket_q <= mrem[BW-1:0];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {3'd0, held_q, fk_q, fv_q, st_q};

endmodule

// ===== hdl/cht_checker.sv =====
// port-level checks of the hash table core, bound to the top level
`timescale 1ns / 1ps

module cht_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [cht_pkg::OutDataW-1:0] m_axis_tdata
);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("ready while result pending");

  // a taken request is not answered the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid && !s_axis_tready)
    else $error("request answered too early");

  // no status code three
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("bad status code");

endmodule

bind chained_hash_table_core cht_checker u_cht_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
